// File: hw/rtl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// Circular deque package
// Shared sizes, operation codes and controller states of the circular deque.
// ----------------------------------------------------------------------------
`default_nettype none

package cdq_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 16;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int CAP_W      = 7;
  localparam int OCC_W      = 7;
  localparam int KIND_W     = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH_FRONT = 3'd0,
    KIND_PUSH_REAR  = 3'd1,
    KIND_POP_FRONT  = 3'd2,
    KIND_POP_REAR   = 3'd3,
    KIND_QUERY      = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/cdq_ram.sv
// ----------------------------------------------------------------------------
// Circular deque RAM
// Generic synchronous RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_ram #(
  parameter  int WIDTH = 16,
  parameter  int DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr_a,
  output logic      [WIDTH-1:0] rd_data_a,
  input  wire logic [AW-1:0]    rd_addr_b,
  output logic      [WIDTH-1:0] rd_data_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_a_r;
  logic [WIDTH-1:0] rd_data_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_a_r <= mem_r[rd_addr_a];
    rd_data_b_r <= mem_r[rd_addr_b];
  end

  assign rd_data_a = rd_data_a_r;
  assign rd_data_b = rd_data_b_r;

endmodule

`default_nettype wire

// File: hw/rtl/circular_deque.sv
// ----------------------------------------------------------------------------
// Circular deque
// Bounded double-ended queue of words held in a ring RAM.
// ----------------------------------------------------------------------------
// The input channel carries one operation per item: push front, push rear,
// pop front, pop rear or query. Each item produces exactly one result item
// with the success flag, the front and rear words, the empty and full flags
// and the occupancy after the operation.
// An item is accepted when in_valid is high and in_stall is low. The ring
// pointers update and a push writes the RAM at that edge; the next cycle
// addresses the front and rear entries, and the registered RAM data is
// loaded into the output register in the load state. A new item is only
// taken once the previous result has been loaded, so the pace is set by the
// address cycle, the registered read of the ring RAM and the output load.
// The output register holds a finished result while out_stall is high;
// the next item is still accepted and waits before the output stage until
// the register is free.
// Reset empties the queue and sets the capacity to 64. A write to the
// capacity register also empties the queue, keeping the RAM contents.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_deque (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [cdq_pkg::KIND_W-1:0]     in_kind,
  input  wire logic [cdq_pkg::DATA_WIDTH-1:0] in_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               out_ok,
  output logic      [cdq_pkg::DATA_WIDTH-1:0] out_front_value,
  output logic      [cdq_pkg::DATA_WIDTH-1:0] out_rear_value,
  output logic                               out_empty_res,
  output logic                               out_full_res,
  output logic      [cdq_pkg::OCC_W-1:0]      out_occupancy,
  input  wire logic                          cfg_wr_en,
  input  wire logic [cdq_pkg::CAP_W-1:0]      cfg_wr_data
);

  import cdq_pkg::*;

  state_t                state_r, state_nxt;
  logic [CAP_W-1:0]      cap_r, cap_nxt;
  logic [IDX_W-1:0]      head_r, head_nxt;
  logic [IDX_W-1:0]      tail_r, tail_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;

  logic                  pend_ok_r, pend_ok_nxt;
  logic                  pend_empty_r, pend_empty_nxt;
  logic                  pend_full_r, pend_full_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_ok_r, out_ok_nxt;
  logic [DATA_WIDTH-1:0] out_front_r, out_front_nxt;
  logic [DATA_WIDTH-1:0] out_rear_r, out_rear_nxt;
  logic                  out_empty_r, out_empty_nxt;
  logic                  out_full_r, out_full_nxt;
  logic [CNT_W-1:0]      out_occ_r, out_occ_nxt;

  logic [CNT_W-1:0]      eff_cap;
  logic [IDX_W-1:0]      cap_last;
  logic [IDX_W-1:0]      head_cur, tail_cur;
  logic [IDX_W-1:0]      head_back, head_fwd, tail_back, tail_fwd;
  logic [IDX_W-1:0]      rear_idx;
  logic                  full_cur, empty_cur;

  logic                  ram_wr_en;
  logic [IDX_W-1:0]      ram_wr_addr;
  logic [DATA_WIDTH-1:0] ram_front, ram_rear;

  always_comb begin
    if (cap_r == '0) begin
      eff_cap = CNT_W'(1);
    end else if (32'(cap_r) > 32'(DEPTH)) begin
      eff_cap = CNT_W'(DEPTH);
    end else begin
      eff_cap = CNT_W'(cap_r);
    end
  end

  assign cap_last  = IDX_W'(eff_cap - CNT_W'(1));
  assign head_cur  = (CNT_W'(head_r) >= eff_cap) ? '0 : head_r;
  assign tail_cur  = (CNT_W'(tail_r) >= eff_cap) ? '0 : tail_r;
  assign head_back = (head_cur == '0) ? cap_last : head_cur - IDX_W'(1);
  assign tail_back = (tail_cur == '0) ? cap_last : tail_cur - IDX_W'(1);
  assign head_fwd  = (CNT_W'(head_cur) + CNT_W'(1) >= eff_cap) ? '0 : head_cur + IDX_W'(1);
  assign tail_fwd  = (CNT_W'(tail_cur) + CNT_W'(1) >= eff_cap) ? '0 : tail_cur + IDX_W'(1);
  assign full_cur  = (count_r >= eff_cap);
  assign empty_cur = (count_r == '0);
  assign rear_idx  = (tail_r == '0) ? cap_last : tail_r - IDX_W'(1);

  assign in_stall = (state_r != ST_IDLE);

  cdq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk       (clk),
    .wr_en     (ram_wr_en),
    .wr_addr   (ram_wr_addr),
    .wr_data   (in_value),
    .rd_addr_a (head_r),
    .rd_data_a (ram_front),
    .rd_addr_b (rear_idx),
    .rd_data_b (ram_rear)
  );

  always_comb begin
    state_nxt      = state_r;
    cap_nxt        = cap_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    pend_ok_nxt    = pend_ok_r;
    pend_empty_nxt = pend_empty_r;
    pend_full_nxt  = pend_full_r;
    out_ok_nxt     = out_ok_r;
    out_front_nxt  = out_front_r;
    out_rear_nxt   = out_rear_r;
    out_empty_nxt  = out_empty_r;
    out_full_nxt   = out_full_r;
    out_occ_nxt    = out_occ_r;
    out_valid_nxt  = out_valid_r && out_stall;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = tail_cur;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt   = ST_READ;
          head_nxt    = head_cur;
          tail_nxt    = tail_cur;
          pend_ok_nxt = 1'b0;
          case (kind_t'(in_kind))
            KIND_PUSH_FRONT: begin
              if (!full_cur) begin
                head_nxt    = head_back;
                ram_wr_en   = 1'b1;
                ram_wr_addr = head_back;
                count_nxt   = count_r + CNT_W'(1);
                pend_ok_nxt = 1'b1;
              end
            end
            KIND_PUSH_REAR: begin
              if (!full_cur) begin
                tail_nxt    = tail_fwd;
                ram_wr_en   = 1'b1;
                ram_wr_addr = tail_cur;
                count_nxt   = count_r + CNT_W'(1);
                pend_ok_nxt = 1'b1;
              end
            end
            KIND_POP_FRONT: begin
              if (!empty_cur) begin
                head_nxt    = head_fwd;
                count_nxt   = count_r - CNT_W'(1);
                pend_ok_nxt = 1'b1;
              end
            end
            KIND_POP_REAR: begin
              if (!empty_cur) begin
                tail_nxt    = tail_back;
                count_nxt   = count_r - CNT_W'(1);
                pend_ok_nxt = 1'b1;
              end
            end
            KIND_QUERY: begin
              pend_ok_nxt = 1'b1;
            end
            default: begin
              pend_ok_nxt = 1'b0;
            end
          endcase
          pend_empty_nxt = (count_nxt == '0);
          pend_full_nxt  = (count_nxt == eff_cap);
        end
      end
      ST_READ: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_ok_nxt    = pend_ok_r;
          out_front_nxt = pend_empty_r ? '0 : ram_front;
          out_rear_nxt  = pend_empty_r ? '0 : ram_rear;
          out_empty_nxt = pend_empty_r;
          out_full_nxt  = pend_full_r;
          out_occ_nxt   = count_r;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_wr_en) begin
      cap_nxt   = cfg_wr_data;
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cap_r       <= CAP_RESET;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_ok_r    <= pend_ok_nxt;
    pend_empty_r <= pend_empty_nxt;
    pend_full_r  <= pend_full_nxt;
    out_ok_r     <= out_ok_nxt;
    out_front_r  <= out_front_nxt;
    out_rear_r   <= out_rear_nxt;
    out_empty_r  <= out_empty_nxt;
    out_full_r   <= out_full_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_ok          = out_ok_r;
  assign out_front_value = out_front_r;
  assign out_rear_value  = out_rear_r;
  assign out_empty_res   = out_empty_r;
  assign out_full_res    = out_full_r;
  assign out_occupancy   = OCC_W'(out_occ_r);

endmodule

`default_nettype wire

// File: hw/rtl/cdq_checker.sv
// ----------------------------------------------------------------------------
// Circular deque checker
// Port-level assertions on the circular deque, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cdq_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic                          out_ok,
  input wire logic [cdq_pkg::DATA_WIDTH-1:0] out_front_value,
  input wire logic [cdq_pkg::DATA_WIDTH-1:0] out_rear_value,
  input wire logic                          out_empty_res,
  input wire logic                          out_full_res,
  input wire logic [cdq_pkg::OCC_W-1:0]      out_occupancy
);

  import cdq_pkg::*;

  // A result held by the receiver stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_front_value)
      && $stable(out_rear_value) && $stable(out_occupancy) && $stable(out_ok))
    else $error("result changed while stalled");

  // One item is worked on at a time, so the input stalls right after an accept.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("item accepted while another is at work");

  // An empty queue reports zero words, zero occupancy and is never full.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_res |-> out_front_value == '0 && out_rear_value == '0
      && out_occupancy == '0 && !out_full_res)
    else $error("empty result carries data");

  // The empty flag follows the occupancy.
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_occupancy == '0 |-> out_empty_res)
    else $error("zero occupancy without empty flag");

endmodule

bind circular_deque cdq_checker u_cdq_checker (.*);

`default_nettype wire
